/* rtl/hvt_pkg.sv */
// Shared types and constants for the hashed variable table.
// Holds the hash constants, status codes, controller states and the
// command and status structs between controller and datapath.
`default_nettype none

package hvt_pkg;

	localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
	localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
	localparam logic        CMD_WRITE = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		RK_READ_HIT,
		RK_WRITE_HIT,
		RK_INSERT,
		RK_NOT_FOUND,
		RK_FULL
	} res_kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_MOD,
		ST_PRD,
		ST_PCHK,
		ST_NCHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic      clr_step;
		logic      load;
		logic      hash_step;
		logic      mod_step;
		logic      idx_rd;
		logic      name_rd;
		logic      probe_next;
		logic      data_rd;
		logic      upd_hit;
		logic      ins;
		logic      res_set;
		res_kind_t res_kind;
		logic      out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic hash_done;
		logic mod_done;
		logic idx_valid;
		logic name_match;
		logic probe_last;
		logic is_write;
		logic table_full;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

/* rtl/hvt_req_if.sv */
// Request channel of the hashed variable table: command, name and value.
// Depends on nothing.
`default_nettype none

interface hvt_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [63:0] var_name;
	logic        value_type;
	logic [31:0] value_bits;

	modport source (output valid, command, var_name, value_type, value_bits, input ready);
	modport sink (input valid, command, var_name, value_type, value_bits, output ready);
endinterface

`default_nettype wire

/* rtl/hvt_rsp_if.sv */
// Response channel of the hashed variable table: status, slot and stored value.
// Depends on nothing.
`default_nettype none

interface hvt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [6:0]  slot_index;
	logic        found_type;
	logic [31:0] found_bits;

	modport source (output valid, status, slot_index, found_type, found_bits, input ready);
	modport sink (input valid, status, slot_index, found_type, found_bits, output ready);
endinterface

`default_nettype wire

/* rtl/hvt_ctrl.sv */
// Controller state machine of the hashed variable table.
// Depends on hvt_pkg; drives the datapath through ctrl_cmd_t.
`default_nettype none

module hvt_ctrl
	import hvt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire dp_stat_t  stat,
	output ctrl_cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_d = ST_HASH;
			end
			ST_HASH: begin
				if (stat.hash_done) state_d = ST_MOD;
			end
			ST_MOD: begin
				if (stat.mod_done) state_d = ST_PRD;
			end
			ST_PRD: begin
				state_d = ST_PCHK;
			end
			ST_PCHK: begin
				state_d = stat.idx_valid ? ST_NCHK : ST_DONE;
			end
			ST_NCHK: begin
				if (stat.name_match || stat.probe_last) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_PRD;
				end
			end
			ST_DONE: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res_kind = RK_NOT_FOUND;
		req_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load = req_valid;
			end
			ST_HASH: cmd.hash_step = !stat.hash_done;
			ST_MOD: cmd.mod_step = 1'b1;
			ST_PRD: cmd.idx_rd = 1'b1;
			ST_PCHK: begin
				if (stat.idx_valid) begin
					cmd.name_rd = 1'b1;
				end else begin
					// An empty entry ends the probe; a write takes the next free slot here.
					cmd.res_set = 1'b1;
					if (!stat.is_write) begin
						cmd.res_kind = RK_NOT_FOUND;
					end else if (stat.table_full) begin
						cmd.res_kind = RK_FULL;
					end else begin
						cmd.res_kind = RK_INSERT;
						cmd.ins = 1'b1;
					end
				end
			end
			ST_NCHK: begin
				if (stat.name_match) begin
					cmd.res_set = 1'b1;
					if (stat.is_write) begin
						cmd.res_kind = RK_WRITE_HIT;
						cmd.upd_hit = 1'b1;
					end else begin
						cmd.res_kind = RK_READ_HIT;
						cmd.data_rd = 1'b1;
					end
				end else if (stat.probe_last) begin
					cmd.res_set = 1'b1;
					cmd.res_kind = stat.is_write ? RK_FULL : RK_NOT_FOUND;
				end else begin
					cmd.probe_next = 1'b1;
				end
			end
			ST_DONE: cmd.out_load = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/hvt_dp.sv */
// Datapath of the hashed variable table: hash unit, modulo unit, probe
// pointer, index, name and value memories, and the output register.
// Depends on hvt_pkg and the two channel interfaces.
`default_nettype none

module hvt_dp
	import hvt_pkg::*;
#(
	parameter int TABLE_SLOTS = 128,
	parameter int INDEX_SIZE  = 256,
	parameter int NAME_BYTES  = 8
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	hvt_req_if.sink        req,
	hvt_rsp_if.source      rsp,
	input  wire ctrl_cmd_t cmd,
	output dp_stat_t       stat
);

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
	localparam int IDX_W  = $clog2(INDEX_SIZE);
	localparam int PC_W   = $clog2(INDEX_SIZE + 1);
	localparam int BC_W   = $clog2(NAME_BYTES + 1);

	localparam logic [31:0]      IDX_N     = 32'(INDEX_SIZE);
	localparam logic [31:0]      IDX_RECIP = 32'(64'h1_0000_0000 / 64'(INDEX_SIZE));
	localparam logic [1:0]       MOD_LAST  = 2'd2;
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(INDEX_SIZE - 1);
	localparam logic [PC_W-1:0]  PC_LAST   = PC_W'(INDEX_SIZE - 1);
	localparam logic [CNT_W-1:0] SLOTS_MAX = CNT_W'(TABLE_SLOTS);
	localparam logic [BC_W-1:0]  BYTES_MAX = BC_W'(NAME_BYTES);

	// Latched item.
	logic              cmd_q;
	logic [63:0]       raw_q;
	logic              vtype_q;
	logic [31:0]       vbits_q;

	// Hash and normalized name.
	logic [31:0]       hash_q;
	logic [63:0]       norm_q;
	logic [BC_W-1:0]   bcnt_q;
	logic [2:0]        byte_sel;
	logic [7:0]        cur_byte;
	logic [31:0]       mixed;

	// Modulo by reciprocal multiplication; the quotient estimate is at most
	// one low, so a single compare and subtract finishes the remainder.
	logic [1:0]        mcnt_q;
	logic [63:0]       recip_prod;
	logic [31:0]       qest_q;
	logic [31:0]       rem_q;
	logic [31:0]       rem_fix;
	logic [IDX_W-1:0]  ptr_q;
	logic [PC_W-1:0]   pcnt_q;

	logic [CNT_W-1:0]  used_q;
	logic [SLOT_W-1:0] free_slot;
	logic [SLOT_W-1:0] hit_slot;

	// Memories and their read registers.
	logic [SLOT_W:0]   idx_mem [INDEX_SIZE];
	logic [SLOT_W:0]   idx_q;
	logic              idx_we;
	logic [SLOT_W:0]   idx_wd;
	logic [63:0]       name_mem [TABLE_SLOTS];
	logic [63:0]       name_q;
	logic [32:0]       data_mem [TABLE_SLOTS];
	logic [32:0]       data_q;
	logic              data_we;
	logic [SLOT_W-1:0] data_wa;

	// Pending result and output register.
	status_t           res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_rd_q;
	logic [31:0]       res_slot_ext;
	logic              out_v_q;
	status_t           out_status_q;
	logic [6:0]        out_slot_q;
	logic              out_type_q;
	logic [31:0]       out_bits_q;

	assign byte_sel   = 3'(bcnt_q);
	assign cur_byte   = raw_q[8*byte_sel +: 8];
	assign mixed      = hash_q ^ {24'd0, cur_byte};
	assign recip_prod = {32'd0, hash_q} * {32'd0, IDX_RECIP};
	assign rem_fix    = (rem_q >= IDX_N) ? rem_q - IDX_N : rem_q;
	assign free_slot  = used_q[SLOT_W-1:0];
	assign hit_slot   = idx_q[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= req.command;
			raw_q   <= req.var_name;
			vtype_q <= req.value_type;
			vbits_q <= req.value_bits;
			hash_q  <= FNV_BASIS;
			norm_q  <= '0;
			bcnt_q  <= '0;
			mcnt_q  <= '0;
			pcnt_q  <= '0;
		end else if (cmd.hash_step) begin
			hash_q  <= mixed * FNV_PRIME;
			norm_q[8*byte_sel +: 8] <= cur_byte;
			bcnt_q  <= bcnt_q + 1'b1;
		end else if (cmd.mod_step) begin
			mcnt_q  <= mcnt_q + 1'b1;
			if (mcnt_q == 2'd0) qest_q <= recip_prod[63:32];
			if (mcnt_q == 2'd1) rem_q <= hash_q - qest_q * IDX_N;
		end else if (cmd.probe_next) begin
			pcnt_q  <= pcnt_q + 1'b1;
		end
	end

	// The probe pointer doubles as the sweep address of the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			used_q <= '0;
		end else begin
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.mod_step) begin
				if (mcnt_q == MOD_LAST) ptr_q <= IDX_W'(rem_fix);
			end else if (cmd.clr_step || cmd.probe_next) begin
				ptr_q <= (ptr_q == IDX_LAST) ? '0 : ptr_q + 1'b1;
			end
			if (cmd.ins) used_q <= used_q + 1'b1;
		end
	end

	assign idx_we = cmd.clr_step | cmd.ins;
	assign idx_wd = cmd.ins ? {1'b1, free_slot} : '0;

	always_ff @(posedge clk) begin
		if (idx_we) idx_mem[ptr_q] <= idx_wd;
		if (cmd.idx_rd) idx_q <= idx_mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) name_mem[free_slot] <= norm_q;
		if (cmd.name_rd) name_q <= name_mem[hit_slot];
	end

	assign data_we = cmd.ins | cmd.upd_hit;
	assign data_wa = cmd.ins ? free_slot : hit_slot;

	always_ff @(posedge clk) begin
		if (data_we) data_mem[data_wa] <= {vtype_q, vbits_q};
		if (cmd.data_rd) data_q <= data_mem[hit_slot];
	end

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			unique case (cmd.res_kind)
				RK_READ_HIT: begin
					res_status_q <= STAT_OK;
					res_slot_q   <= hit_slot;
					res_rd_q     <= 1'b1;
				end
				RK_WRITE_HIT: begin
					res_status_q <= STAT_OK;
					res_slot_q   <= hit_slot;
					res_rd_q     <= 1'b0;
				end
				RK_INSERT: begin
					res_status_q <= STAT_OK;
					res_slot_q   <= free_slot;
					res_rd_q     <= 1'b0;
				end
				RK_FULL: begin
					res_status_q <= STAT_FULL;
					res_slot_q   <= '0;
					res_rd_q     <= 1'b0;
				end
				default: begin
					res_status_q <= STAT_NOT_FOUND;
					res_slot_q   <= '0;
					res_rd_q     <= 1'b0;
				end
			endcase
		end
	end

	assign res_slot_ext = 32'(res_slot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_ext[6:0];
			out_type_q   <= res_rd_q & data_q[32];
			out_bits_q   <= res_rd_q ? data_q[31:0] : 32'd0;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.status     = out_status_q;
	assign rsp.slot_index = out_slot_q;
	assign rsp.found_type = out_type_q;
	assign rsp.found_bits = out_bits_q;

	always_comb begin
		stat            = '0;
		stat.clr_done   = (ptr_q == IDX_LAST);
		stat.hash_done  = (bcnt_q == BYTES_MAX) || (cur_byte == 8'd0);
		stat.mod_done   = (mcnt_q == MOD_LAST);
		stat.idx_valid  = idx_q[SLOT_W];
		stat.name_match = (name_q == norm_q);
		stat.probe_last = (pcnt_q == PC_LAST);
		stat.is_write   = (cmd_q == CMD_WRITE);
		stat.table_full = (used_q == SLOTS_MAX);
		stat.out_free   = !out_v_q || rsp.ready;
	end

endmodule

`default_nettype wire

/* rtl/hashed_variable_table_top.sv */
// Top level of the hashed variable table: joins controller and datapath.
// Depends on hvt_pkg, hvt_req_if, hvt_rsp_if, hvt_ctrl and hvt_dp.
//
//   channel  direction  fields
//   req      in         command, var_name, value_type, value_bits
//   rsp      out        status, slot_index, found_type, found_bits
//
// From acceptance to the response register, a word's name bytes are hashed one
// per cycle through the FNV multiplier, plus a step to see the end; the hash is
// reduced modulo INDEX_SIZE by a reciprocal multiply; and each index entry
// visited takes an index read, an entry check and a name check (no name check
// for the empty entry that ends a probe).
// After reset the index memory is swept clear with req.ready low.
// The response register lets a new word in while the last response waits; a
// finished lookup waits in its last state until that register is free.
`default_nettype none

module hashed_variable_table_top
	import hvt_pkg::*;
#(
	parameter int TABLE_SLOTS = 128,
	parameter int INDEX_SIZE  = 256,
	parameter int NAME_BYTES  = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	hvt_req_if.sink   req,
	hvt_rsp_if.source rsp
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      ready;

	hvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	hvt_dp #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.INDEX_SIZE  (INDEX_SIZE),
		.NAME_BYTES  (NAME_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.stat   (stat)
	);

	assign req.ready = ready;

endmodule

`default_nettype wire

/* bench/hashed_variable_table_top_test.sv */
// Self-checking bench for the hashed variable table: named reads, writes and creates.
// Depends on hvt_pkg, hvt_req_if, hvt_rsp_if and hashed_variable_table_top.
// A scoreboard class predicts every response word and checks it in order.
`default_nettype none

module hashed_variable_table_top_test;
	import hvt_pkg::*;

	localparam int SLOTS = 128;
	localparam int INDEX_LEN = 256;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  slot_index;
		logic        found_type;
		logic [31:0] found_bits;
	} answer_t;

	class var_table_scoreboard;
		logic [63:0] names[SLOTS];
		bit          in_use[SLOTS];
		logic        types[SLOTS];
		logic [31:0] payloads[SLOTS];
		int          index_slot[INDEX_LEN];
		bit          index_full[INDEX_LEN];
		answer_t     pending[$];
		int          errors;
		int          reads, writes, creates, misses, fulls;

		function void clear();
			for (int i = 0; i < SLOTS; i++) in_use[i] = 0;
			for (int i = 0; i < INDEX_LEN; i++) index_full[i] = 0;
		endfunction

		function logic [63:0] trim_name(logic [63:0] raw);
			logic [63:0] r;
			r = '0;
			for (int i = 0; i < 8; i++) begin
				if (raw[8*i +: 8] == 8'd0) break;
				r[8*i +: 8] = raw[8*i +: 8];
			end
			return r;
		endfunction

		function logic [31:0] fnv(logic [63:0] nm);
			logic [31:0] h;
			h = FNV_BASIS;
			for (int i = 0; i < 8; i++) begin
				if (nm[8*i +: 8] == 8'd0) break;
				h = (h ^ {24'd0, nm[8*i +: 8]}) * FNV_PRIME;
			end
			return h;
		endfunction

		function int find_slot(logic [63:0] nm);
			int h;
			h = fnv(nm) % INDEX_LEN;
			for (int p = 0; p < INDEX_LEN; p++) begin
				if (!index_full[h]) return -1;
				if (in_use[index_slot[h]] && names[index_slot[h]] == nm) return index_slot[h];
				h = (h + 1) % INDEX_LEN;
			end
			return -1;
		endfunction

		function void note_request(logic cmd, logic [63:0] raw, logic vt, logic [31:0] vb);
			logic [63:0] nm;
			int s, fs, fe, h;
			answer_t a;
			nm = trim_name(raw);
			s = find_slot(nm);
			a = '0;
			if (cmd != CMD_WRITE) begin
				reads++;
				if (s < 0) begin
					a.status = STAT_NOT_FOUND;
					misses++;
				end else begin
					a.slot_index = 7'(s);
					a.found_type = types[s];
					a.found_bits = payloads[s];
				end
			end else if (s >= 0) begin
				writes++;
				types[s] = vt;
				payloads[s] = vb;
				a.slot_index = 7'(s);
			end else begin
				fs = -1;
				fe = -1;
				for (int i = 0; i < SLOTS; i++)
					if (!in_use[i]) begin
						fs = i;
						break;
					end
				h = fnv(nm) % INDEX_LEN;
				for (int i = 0; i < INDEX_LEN; i++) begin
					if (!index_full[h]) begin
						fe = h;
						break;
					end
					h = (h + 1) % INDEX_LEN;
				end
				if (fs < 0 || fe < 0) begin
					a.status = STAT_FULL;
					fulls++;
				end else begin
					creates++;
					in_use[fs] = 1;
					names[fs] = nm;
					types[fs] = vt;
					payloads[fs] = vb;
					index_slot[fe] = fs;
					index_full[fe] = 1;
					a.slot_index = 7'(fs);
				end
			end
			pending.push_back(a);
		endfunction

		function void check_answer(answer_t got);
			answer_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected response word %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.slot_index !== want.slot_index) begin
				$display("%0t: slot_index expected %0d actual %0d", $time,
					want.slot_index, got.slot_index);
				errors++;
			end
			if (got.found_type !== want.found_type) begin
				$display("%0t: found_type expected %0d actual %0d", $time,
					want.found_type, got.found_type);
				errors++;
			end
			if (got.found_bits !== want.found_bits) begin
				$display("%0t: found_bits expected %h actual %h", $time,
					want.found_bits, got.found_bits);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	hvt_req_if req ();
	hvt_rsp_if rsp ();

	hashed_variable_table_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	var_table_scoreboard board;
	bit  calm;
	int  idle_cycles;
	logic [63:0] name_pool[40];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		board = new();
		board.clear();
		req.valid = 1'b0;
		req.command = 1'b0;
		req.var_name = '0;
		req.value_type = 1'b0;
		req.value_bits = '0;
		rsp.ready = 1'b0;
		calm = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Checks and notes words on the same edge that moves them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				board.note_request(req.command, req.var_name, req.value_type, req.value_bits);
			if (rsp.valid && rsp.ready)
				board.check_answer({rsp.status, rsp.slot_index, rsp.found_type, rsp.found_bits});
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end else
			idle_cycles <= 0;
	end

	// Receiver stalls in bursts, with calm stretches.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 15);
				rsp.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	// Valid stays high from one word to the next unless an idle burst comes;
	// callers lower it before waiting for responses to drain.
	task automatic send_word(logic cmd, logic [63:0] nm, logic vt, logic [31:0] vb);
		if (!calm && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= cmd;
		req.var_name <= nm;
		req.value_type <= vt;
		req.value_bits <= vb;
		do @(posedge clk); while (!req.ready);
	endtask

	function automatic logic [63:0] random_name();
		logic [63:0] nm;
		int len;
		len = $urandom_range(0, 8);
		nm = {$urandom, $urandom};
		for (int i = 0; i < 8; i++)
			if (i >= len) nm[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
		return nm;
	endfunction

	initial begin
		logic [63:0] nm;
		@(posedge arst_n);
		@(posedge clk);
		// Directed part: empty name, trailing junk after a zero byte, full-width names.
		send_word(1'b0, 64'd0, 1'b0, '0);
		send_word(CMD_WRITE, 64'd0, 1'b1, 32'hFFFF_FFFF);
		send_word(1'b0, 64'hFF00_0000_0000_0000, 1'b0, '0);
		send_word(CMD_WRITE, 64'h0000_0000_0000_0041, 1'b0, 32'h3F80_0000);
		send_word(1'b0, 64'hABCD_EF00_1234_0041, 1'b1, '1);
		send_word(CMD_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h0000_0001);
		send_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
		send_word(CMD_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h8000_0000);
		send_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
		send_word(1'b0, 64'h0101_0101_0101_0101, 1'b0, '0);
		send_word(CMD_WRITE, 64'h0101_0101_0101_0101, 1'b1, 32'h5555_AAAA);
		send_word(1'b0, 64'h0101_0101_0101_0101, 1'b0, '0);
		for (int i = 0; i < 40; i++) name_pool[i] = random_name();
		// Random reads and writes, mostly over a reused pool of names.
		for (int i = 0; i < 500; i++) begin
			nm = ($urandom_range(0, 4) == 0) ? random_name() : name_pool[$urandom_range(0, 39)];
			send_word(1'($urandom), nm, 1'($urandom), $urandom);
		end
		// Let every response drain before continuing.
		req.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		// Fill the table past its 128 slots so the full case shows up.
		for (int i = 0; i < 200; i++)
			send_word(CMD_WRITE, {32'($urandom), 24'($urandom), 8'(i | 1)}, 1'($urandom), $urandom);
		for (int i = 0; i < 500; i++) begin
			if (i == 380) calm = 1;
			nm = ($urandom_range(0, 2) == 0) ? random_name() : name_pool[$urandom_range(0, 39)];
			send_word(1'($urandom), nm, 1'($urandom), $urandom);
		end
		req.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
		$display("Covered %0d reads (%0d misses), %0d overwrites, %0d creates, %0d full.",
			board.reads, board.misses, board.writes, board.creates, board.fulls);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
